// File: rtl/rsqe_pkg.sv
// ----------------------------------------------------------------------------
// rsqe_pkg
// Shared types, constants and tables for the rotated sprite quad expander.
// ----------------------------------------------------------------------------
package rsqe_pkg;

  localparam int IndexBits   = 16;
  localparam int AngleBits   = 16;
  localparam int Corners     = 4;
  localparam int IndexCount  = 6;
  localparam int CordicSteps = 20;

  localparam int PhaseDrop = 32 - AngleBits;
  localparam logic [31:0] PhaseKeep = ~((32'd1 << PhaseDrop) - 32'd1);

  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic signed [33:0] OneQ30  = 34'sd1073741824;

  typedef enum logic [2:0] {
    StIdle,
    StCordic,
    StMac,
    StVertOut,
    StIndexOut
  } state_e;

  typedef struct packed {
    logic start;
  } mac_ctrl_t;

  typedef struct packed {
    logic done;
  } mac_stat_t;

  function automatic logic signed [32:0] atan_lut(input logic [4:0] i);
    logic signed [32:0] r;
    unique case (i)
      5'd0:    r = 33'sd536870912;
      5'd1:    r = 33'sd316933406;
      5'd2:    r = 33'sd167458907;
      5'd3:    r = 33'sd85004756;
      5'd4:    r = 33'sd42667331;
      5'd5:    r = 33'sd21354465;
      5'd6:    r = 33'sd10679838;
      5'd7:    r = 33'sd5340245;
      5'd8:    r = 33'sd2670163;
      5'd9:    r = 33'sd1335087;
      5'd10:   r = 33'sd667544;
      5'd11:   r = 33'sd333772;
      5'd12:   r = 33'sd166886;
      5'd13:   r = 33'sd83443;
      5'd14:   r = 33'sd41722;
      5'd15:   r = 33'sd20861;
      5'd16:   r = 33'sd10430;
      5'd17:   r = 33'sd5215;
      5'd18:   r = 33'sd2608;
      5'd19:   r = 33'sd1304;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

  // triangle list order tl,tr,bl,tr,br,bl
  function automatic logic [1:0] tri_offset(input logic [2:0] j);
    logic [1:0] r;
    unique case (j)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      3'd4:    r = 2'd3;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/rsqe_cordic.sv
// ----------------------------------------------------------------------------
// rsqe_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, with quadrant fold.
// ----------------------------------------------------------------------------
module rsqe_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [15:0]         angle_i,
  output logic                done_o,
  output logic signed [31:0]  cos_o,
  output logic signed [31:0]  sin_o
);

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [32:0] z_q, z_d;
  logic [1:0]         quad_q, quad_d;
  logic [4:0]         step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [31:0]        phase;
  logic signed [33:0] xs, ys, xc, yc;

  assign phase = {angle_i, 16'd0} & rsqe_pkg::PhaseKeep;
  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    quad_d = quad_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = rsqe_pkg::CordicK;
      y_d    = '0;
      z_d    = 33'($unsigned(phase[29:0]));
      quad_d = phase[31:30];
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - rsqe_pkg::atan_lut(step_q);
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + rsqe_pkg::atan_lut(step_q);
      end
      step_d = step_q + 5'd1;
      if (step_q == 5'(rsqe_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
  end

  always_comb begin
    xc = x_q;
    yc = y_q;
    if (x_q > rsqe_pkg::OneQ30) xc = rsqe_pkg::OneQ30;
    if (x_q < -rsqe_pkg::OneQ30) xc = -rsqe_pkg::OneQ30;
    if (y_q > rsqe_pkg::OneQ30) yc = rsqe_pkg::OneQ30;
    if (y_q < -rsqe_pkg::OneQ30) yc = -rsqe_pkg::OneQ30;
    unique case (quad_q)
      2'd0: begin cos_o = 32'(xc);  sin_o = 32'(yc);  end
      2'd1: begin cos_o = 32'(-yc); sin_o = 32'(xc);  end
      2'd2: begin cos_o = 32'(-xc); sin_o = 32'(-yc); end
      default: begin cos_o = 32'(yc); sin_o = 32'(-xc); end
    endcase
  end

  assign done_o = done_q;

endmodule

// File: rtl/rsqe_mac.sv
// ----------------------------------------------------------------------------
// rsqe_mac
// Shared multiplier with rounding accumulator, four products per corner.
// ----------------------------------------------------------------------------
module rsqe_mac (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rsqe_pkg::mac_ctrl_t     ctrl_i,
  input  logic signed [33:0]      dx_i,
  input  logic signed [33:0]      dy_i,
  input  logic signed [31:0]      cos_i,
  input  logic signed [31:0]      sin_i,
  output rsqe_pkg::mac_stat_t     stat_o,
  output logic signed [36:0]      rot_x_o,
  output logic signed [36:0]      rot_y_o
);

  logic [2:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [1:0]         prev_q;
  logic signed [33:0] op_a;
  logic signed [31:0] op_b;
  logic signed [65:0] prod_q, biased;
  logic signed [35:0] rnd;
  logic signed [36:0] ax_q, ay_q;

  // product order dx*cos, dy*sin, dx*sin, dy*cos
  assign op_a   = cnt_q[0] ? dy_i : dx_i;
  assign op_b   = (cnt_q[1:0] == 2'd0 || cnt_q[1:0] == 2'd3) ? cos_i : sin_i;
  assign biased = prod_q + 66'sd536870912;
  assign rnd    = 36'(biased >>> 30);

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd4) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prod_q <= 66'(op_a) * 66'(op_b);
      prev_q <= cnt_q[1:0];
      if (cnt_q != 3'd0) begin
        unique case (prev_q)
          2'd0:    ax_q <= 37'(rnd);
          2'd1:    ax_q <= ax_q - 37'(rnd);
          2'd2:    ay_q <= 37'(rnd);
          default: ay_q <= ay_q + 37'(rnd);
        endcase
      end
    end
  end

  assign stat_o.done = done_q;
  assign rot_x_o     = ax_q;
  assign rot_y_o     = ay_q;

endmodule

// File: rtl/rotated_sprite_quad_expander_top.sv
// ----------------------------------------------------------------------------
// rotated_sprite_quad_expander_top
// Expands one sprite into four rotated vertices and six triangle indices.
// ----------------------------------------------------------------------------
// channel | dir | handshake                 | payload
// in      | in  | in_valid_i / in_ready_o   | sprite corners, uvs, pivot, angle
// out     | out | out_valid_o / out_ready_i | vertex or index result
//
// a sprite passes through the cordic iterations, then per corner the multiply
// sequence and one vertex transfer, then six index transfers; the cordic loop
// and the single multiplier set the time per sprite
// in_ready_o is high only when idle; out stalls hold the current result
// reset clears the vertex counter to zero
module rotated_sprite_quad_expander_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [31:0]  left_x_i,
  input  logic [31:0]  top_y_i,
  input  logic [31:0]  right_x_i,
  input  logic [31:0]  bottom_y_i,
  input  logic [15:0]  uv_left_i,
  input  logic [15:0]  uv_top_i,
  input  logic [15:0]  uv_right_i,
  input  logic [15:0]  uv_bottom_i,
  input  logic [31:0]  origin_x_i,
  input  logic [31:0]  origin_y_i,
  input  logic [63:0]  pivot_offset_xy_i,
  input  logic [15:0]  angle_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         is_index_o,
  output logic [31:0]  vert_x_o,
  output logic [31:0]  vert_y_o,
  output logic [15:0]  tex_u_o,
  output logic [15:0]  tex_v_o,
  output logic [15:0]  vertex_index_o,
  output logic         last_o
);

  localparam int IB = rsqe_pkg::IndexBits;

  rsqe_pkg::state_e state_q, state_d;
  logic [1:0]  corner_q, corner_d;
  logic [2:0]  idx_q, idx_d;
  logic [IB-1:0] next_vertex_q, next_vertex_d;
  logic        cord_start_q, cord_start_d;
  logic        mac_start_q, mac_start_d;
  logic        in_xfer, out_xfer, cord_done;

  logic signed [31:0] lx_q, ty_q, rx_q, by_q;
  logic [15:0]        ul_q, vt_q, ur_q, vb_q, angle_q;
  logic signed [32:0] px_q, py_q;

  logic signed [31:0] cs, sn;
  logic signed [33:0] dx, dy;
  logic signed [31:0] cx, cy;
  logic signed [36:0] rot_x, rot_y;
  logic signed [37:0] sum_x, sum_y;
  logic [31:0]        sat_x, sat_y;
  logic [IB-1:0]      vidx;
  rsqe_pkg::mac_ctrl_t mac_ctrl;
  rsqe_pkg::mac_stat_t mac_stat;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      lx_q    <= left_x_i;
      ty_q    <= top_y_i;
      rx_q    <= right_x_i;
      by_q    <= bottom_y_i;
      ul_q    <= uv_left_i;
      vt_q    <= uv_top_i;
      ur_q    <= uv_right_i;
      vb_q    <= uv_bottom_i;
      angle_q <= angle_i;
      px_q    <= 33'($signed(origin_x_i)) + 33'($signed(pivot_offset_xy_i[63:32]));
      py_q    <= 33'($signed(origin_y_i)) + 33'($signed(pivot_offset_xy_i[31:0]));
    end
  end

  rsqe_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start_q),
    .angle_i (angle_q),
    .done_o  (cord_done),
    .cos_o   (cs),
    .sin_o   (sn)
  );

  assign cx = corner_q[0] ? rx_q : lx_q;
  assign cy = corner_q[1] ? by_q : ty_q;
  assign dx = 34'(cx) - 34'(px_q);
  assign dy = 34'(cy) - 34'(py_q);
  assign mac_ctrl.start = mac_start_q;

  rsqe_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .dx_i    (dx),
    .dy_i    (dy),
    .cos_i   (cs),
    .sin_i   (sn),
    .stat_o  (mac_stat),
    .rot_x_o (rot_x),
    .rot_y_o (rot_y)
  );

  assign sum_x = 38'(rot_x) + 38'(px_q);
  assign sum_y = 38'(rot_y) + 38'(py_q);

  always_comb begin
    sat_x = sum_x[31:0];
    sat_y = sum_y[31:0];
    if (sum_x > 38'sd2147483647) sat_x = 32'h7fff_ffff;
    if (sum_x < -38'sd2147483648) sat_x = 32'h8000_0000;
    if (sum_y > 38'sd2147483647) sat_y = 32'h7fff_ffff;
    if (sum_y < -38'sd2147483648) sat_y = 32'h8000_0000;
  end

  // next state
  always_comb begin
    state_d       = state_q;
    corner_d      = corner_q;
    idx_d         = idx_q;
    next_vertex_d = next_vertex_q;
    cord_start_d  = 1'b0;
    mac_start_d   = 1'b0;
    unique case (state_q)
      rsqe_pkg::StIdle: begin
        if (in_xfer) begin
          state_d      = rsqe_pkg::StCordic;
          cord_start_d = 1'b1;
          corner_d     = '0;
          idx_d        = '0;
        end
      end
      rsqe_pkg::StCordic: begin
        if (cord_done) begin
          state_d     = rsqe_pkg::StMac;
          mac_start_d = 1'b1;
        end
      end
      rsqe_pkg::StMac: begin
        if (mac_stat.done) state_d = rsqe_pkg::StVertOut;
      end
      rsqe_pkg::StVertOut: begin
        if (out_xfer) begin
          corner_d = corner_q + 2'd1;
          if (corner_q == 2'(rsqe_pkg::Corners - 1)) begin
            state_d = rsqe_pkg::StIndexOut;
          end else begin
            state_d     = rsqe_pkg::StMac;
            mac_start_d = 1'b1;
          end
        end
      end
      rsqe_pkg::StIndexOut: begin
        if (out_xfer) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'(rsqe_pkg::IndexCount - 1)) begin
            state_d       = rsqe_pkg::StIdle;
            next_vertex_d = next_vertex_q + IB'(rsqe_pkg::Corners);
          end
        end
      end
      default: state_d = rsqe_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rsqe_pkg::StIdle;
      corner_q      <= '0;
      idx_q         <= '0;
      next_vertex_q <= '0;
      cord_start_q  <= 1'b0;
      mac_start_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      corner_q      <= corner_d;
      idx_q         <= idx_d;
      next_vertex_q <= next_vertex_d;
      cord_start_q  <= cord_start_d;
      mac_start_q   <= mac_start_d;
    end
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    is_index_o     = 1'b0;
    vert_x_o       = '0;
    vert_y_o       = '0;
    tex_u_o        = '0;
    tex_v_o        = '0;
    last_o         = 1'b0;
    vidx           = next_vertex_q + IB'(corner_q);
    unique case (state_q)
      rsqe_pkg::StIdle: in_ready_o = 1'b1;
      rsqe_pkg::StVertOut: begin
        out_valid_o = 1'b1;
        vert_x_o    = sat_x;
        vert_y_o    = sat_y;
        tex_u_o     = corner_q[0] ? ur_q : ul_q;
        tex_v_o     = corner_q[1] ? vb_q : vt_q;
      end
      rsqe_pkg::StIndexOut: begin
        out_valid_o = 1'b1;
        is_index_o  = 1'b1;
        vidx        = next_vertex_q + IB'(rsqe_pkg::tri_offset(idx_q));
        last_o      = (idx_q == 3'(rsqe_pkg::IndexCount - 1));
      end
      default: ;
    endcase
    vertex_index_o = 16'(vidx);
  end

endmodule

// File: rtl/rsqe_checker.sv
// ----------------------------------------------------------------------------
// rsqe_props
// Port-level checks on the quad expander, bound to the top level.
// ----------------------------------------------------------------------------
module rsqe_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        is_index_o,
  input logic [31:0] vert_x_o,
  input logic [15:0] vertex_index_o,
  input logic        last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vert_x_o)
      && $stable(vertex_index_o) && $stable(is_index_o))
    else $error("stalled result changed");

  // no new sprite taken while results are pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while results pending");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> is_index_o)
    else $error("last on a vertex result");

  // after the final index transfer the block is ready again
  a_ready_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> in_ready_o)
    else $error("not ready after last transfer");

endmodule

bind rotated_sprite_quad_expander_top rsqe_props u_rsqe_props (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .is_index_o     (is_index_o),
  .vert_x_o       (vert_x_o),
  .vertex_index_o (vertex_index_o),
  .last_o         (last_o)
);

// File: sim/rsqe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsqe_checker
// Watches both channels of the sprite quad expander, predicts the four
// rotated vertices and six triangle indices of every sprite transfer, and
// compares each output transfer with the oldest prediction in order.
// ----------------------------------------------------------------------------
module rsqe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] left_x_i,
  input  logic [31:0] top_y_i,
  input  logic [31:0] right_x_i,
  input  logic [31:0] bottom_y_i,
  input  logic [15:0] uv_left_i,
  input  logic [15:0] uv_top_i,
  input  logic [15:0] uv_right_i,
  input  logic [15:0] uv_bottom_i,
  input  logic [31:0] origin_x_i,
  input  logic [31:0] origin_y_i,
  input  logic [63:0] pivot_offset_xy_i,
  input  logic [15:0] angle_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        is_index_i,
  input  logic [31:0] vert_x_i,
  input  logic [31:0] vert_y_i,
  input  logic [15:0] tex_u_i,
  input  logic [15:0] tex_v_i,
  input  logic [15:0] vertex_index_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          sprites_o,
  output int          results_o
);

  typedef struct packed {
    logic        is_index;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] idx;
    logic        last;
  } vertex_rec_t;

  localparam longint AtanTurns[rsqe_pkg::CordicSteps] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304};

  vertex_rec_t  expected_q[$];
  logic [rsqe_pkg::IndexBits-1:0] vertex_count;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd30(longint p);
    return fshr(p + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic rotation_of(input logic [15:0] ang, output longint cs, output longint sn);
    logic [31:0] phase;
    longint x, y, z, xs, ys;
    phase = {ang, 16'd0} & rsqe_pkg::PhaseKeep;
    x = rsqe_pkg::CordicK;
    y = 0;
    z = longint'({2'b00, phase[29:0]});
    for (int i = 0; i < rsqe_pkg::CordicSteps; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= AtanTurns[i];
      end else begin
        x += ys; y -= xs; z += AtanTurns[i];
      end
    end
    if (x > rsqe_pkg::OneQ30) x = rsqe_pkg::OneQ30;
    if (x < -rsqe_pkg::OneQ30) x = -rsqe_pkg::OneQ30;
    if (y > rsqe_pkg::OneQ30) y = rsqe_pkg::OneQ30;
    if (y < -rsqe_pkg::OneQ30) y = -rsqe_pkg::OneQ30;
    case (phase[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endtask

  task automatic expand_sprite();
    longint px, py, cs, sn, dx, dy, xr, yr;
    longint cx[4], cy[4];
    logic [15:0] cu[4], cv[4];
    logic [1:0] tri_ofs[6];
    vertex_rec_t r;
    tri_ofs = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2};
    px = longint'($signed(origin_x_i)) + longint'($signed(pivot_offset_xy_i[63:32]));
    py = longint'($signed(origin_y_i)) + longint'($signed(pivot_offset_xy_i[31:0]));
    cx = '{$signed(left_x_i), $signed(right_x_i), $signed(left_x_i), $signed(right_x_i)};
    cy = '{$signed(top_y_i), $signed(top_y_i), $signed(bottom_y_i), $signed(bottom_y_i)};
    cu = '{uv_left_i, uv_right_i, uv_left_i, uv_right_i};
    cv = '{uv_top_i, uv_top_i, uv_bottom_i, uv_bottom_i};
    rotation_of(angle_i, cs, sn);
    for (int k = 0; k < rsqe_pkg::Corners; k++) begin
      dx = cx[k] - px;
      dy = cy[k] - py;
      xr = rnd30(dx * cs) - rnd30(dy * sn);
      yr = rnd30(dx * sn) + rnd30(dy * cs);
      r = '0;
      r.vx = sat32(xr + px);
      r.vy = sat32(yr + py);
      r.u = cu[k];
      r.v = cv[k];
      r.idx = vertex_count + rsqe_pkg::IndexBits'(k);
      expected_q.push_back(r);
    end
    for (int k = 0; k < rsqe_pkg::IndexCount; k++) begin
      r = '0;
      r.is_index = 1'b1;
      r.idx = vertex_count + rsqe_pkg::IndexBits'(tri_ofs[k]);
      r.last = (k == rsqe_pkg::IndexCount - 1);
      expected_q.push_back(r);
    end
    vertex_count = vertex_count + rsqe_pkg::IndexBits'(rsqe_pkg::Corners);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_rec_t e, a;
    if (!rst_ni) begin
      vertex_count = '0;
      fail_count_o <= 0;
      pending_o <= 0;
      sprites_o <= 0;
      results_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expand_sprite();
        sprites_o <= sprites_o + 1;
      end
      if (out_valid_i && out_ready_i) begin
        a = '{is_index_i, vert_x_i, vert_y_i, tex_u_i, tex_v_i, vertex_index_i, last_i};
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, a);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e != a) begin
            $display("%0t: mismatch, expected %p actual %p", $time, e, a);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end
endmodule

// File: sim/rotated_sprite_quad_expander_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_sprite_quad_expander_top_tb
// Drives directed and random sprites through the quad expander with random
// idling on both channels, a long receiver hold-off and a drain pause; the
// checker module predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module rotated_sprite_quad_expander_top_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] left_x_i = '0, top_y_i = '0, right_x_i = '0, bottom_y_i = '0;
  logic [15:0] uv_left_i = '0, uv_top_i = '0, uv_right_i = '0, uv_bottom_i = '0;
  logic [31:0] origin_x_i = '0, origin_y_i = '0;
  logic [63:0] pivot_offset_xy_i = '0;
  logic [15:0] angle_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic is_index_o, last_o;
  logic [31:0] vert_x_o, vert_y_o;
  logic [15:0] tex_u_o, tex_v_o, vertex_index_o;

  int fail_count, pending, sprites, results;
  int cycle_count = 0;
  bit calm_phase = 0;
  bit hold_off = 0;

  rotated_sprite_quad_expander_top u_dut (.*);

  rsqe_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .left_x_i, .top_y_i,
    .right_x_i, .bottom_y_i, .uv_left_i, .uv_top_i, .uv_right_i, .uv_bottom_i,
    .origin_x_i, .origin_y_i, .pivot_offset_xy_i, .angle_i,
    .out_valid_i(out_valid_o), .out_ready_i, .is_index_i(is_index_o),
    .vert_x_i(vert_x_o), .vert_y_i(vert_y_o), .tex_u_i(tex_u_o), .tex_v_i(tex_v_o),
    .vertex_index_i(vertex_index_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .sprites_o(sprites),
    .results_o(results)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("rotated_sprite_quad_expander_top verification failed");
      $finish;
    end
  end

  // receiver idling
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  task automatic send_sprite(logic [31:0] lx, ty, rx, by, logic [15:0] ul, vt, ur, vb,
                             logic [31:0] ox, oy, logic [63:0] po, logic [15:0] ang);
    left_x_i <= lx; top_y_i <= ty; right_x_i <= rx; bottom_y_i <= by;
    uv_left_i <= ul; uv_top_i <= vt; uv_right_i <= ur; uv_bottom_i <= vb;
    origin_x_i <= ox; origin_y_i <= oy; pivot_offset_xy_i <= po; angle_i <= ang;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (!calm_phase && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int mode);
    send_sprite(rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
                16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                rand_coord(mode), rand_coord(mode),
                {rand_coord(mode), rand_coord(mode)}, 16'($urandom()));
  endtask

  initial begin
    logic [15:0] angles[8];
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2000, 16'h0001, 16'h7fff};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (angles[i])
      send_sprite(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'h0007_0000,
                  16'h0000, 16'h1234, 16'hffff, 16'h8000, 32'h0000_8000,
                  32'hffff_0000, 64'h0001_0000_fffe_0000, angles[i]);
    // reversed corners and rail values
    send_sprite(32'h0005_0000, 32'h0007_0000, 32'h0001_0000, 32'h0002_0000,
                16'hffff, 16'hffff, 16'h0000, 16'h0000, '0, '0, '0, 16'h1000);
    send_sprite(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 32'h7fff_ffff, 32'h8000_0000,
                64'h7fff_ffff_8000_0000, 16'h6000);
    send_sprite(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                16'h0001, 16'h8000, 16'h7fff, 16'hfffe, 32'h8000_0000, 32'h7fff_ffff,
                64'h8000_0000_7fff_ffff, 16'ha000);
    send_sprite('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 16'hffff);
    for (int i = 0; i < 4; i++) send_random(i);
    // long receiver hold-off while offering sprites
    hold_off = 1;
    repeat (4) send_random(3);
    // drain pause
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (int i = 0; i < 80; i++) begin
      if (i == 60) calm_phase = 1;
      send_random($urandom_range(0, 5) == 0 ? $urandom_range(0, 2) : 3);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d sprites and %0d results: all quadrants, rails, reversed corners,",
             sprites, results);
    $display("random stalls, a long output hold-off and a full drain pause");
    if (fail_count == 0) begin
      $display("rotated_sprite_quad_expander_top verification clean");
    end else begin
      $display("rotated_sprite_quad_expander_top verification failed");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/rsqe_pkg.sv
rtl/rsqe_cordic.sv
rtl/rsqe_mac.sv
rtl/rotated_sprite_quad_expander_top.sv
rtl/rsqe_checker.sv
sim/rsqe_checker.sv
sim/rotated_sprite_quad_expander_top_tb.sv
